// ===== rtl/thst_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermostat package
// Shared types and constants for the two-stage thermostat controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package thst_pkg;

   // Field widths
   localparam int TempWidth     = 12;
   localparam int HystWidth     = 10;
   localparam int DelayWidth    = 6;
   localparam int WaitWidth     = 12;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 12;

   // Delay reload scale and counter reset value
   localparam logic [WaitWidth-1:0] TicksPerSetting = 12'd60;
   localparam logic [WaitWidth-1:0] WaitReset       = 12'd60;

   // Register reset values
   localparam logic signed [TempWidth-1:0] SetpointReset  = 12'sd200;
   localparam logic [HystWidth-1:0]        HystReset      = 10'd5;
   localparam logic [HystWidth-1:0]        Hyst2Reset     = 10'd40;
   localparam logic                        ProbeEnReset   = 1'b0;
   localparam logic [DelayWidth-1:0]       CoolDelayReset = 6'd5;
   localparam logic [DelayWidth-1:0]       HeatDelayReset = 6'd2;

   // Register map
   typedef enum logic [CsrIndexWidth-1:0] {
      REG_SETPOINT    = 3'd0,
      REG_HYSTERESIS  = 3'd1,
      REG_HYSTERESIS2 = 3'd2,
      REG_PROBE2_EN   = 3'd3,
      REG_COOL_DELAY  = 3'd4,
      REG_HEAT_DELAY  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [TempWidth-1:0] setpoint;
      logic [HystWidth-1:0]        hysteresis;
      logic [HystWidth-1:0]        second_hysteresis;
      logic                        second_probe_enable;
      logic [DelayWidth-1:0]       cool_delay_setting;
      logic [DelayWidth-1:0]       heat_delay_setting;
   } cfg_type;

   typedef struct packed {
      logic [WaitWidth-1:0] cool_wait;
      logic [WaitWidth-1:0] heat_wait;
      logic                 cool_on;
      logic                 heat_on;
   } state_type;

   typedef struct packed {
      logic cool_relay;
      logic heat_relay;
      logic cool_lamp;
      logic heat_lamp;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/thst_csr.sv =====
// ----------------------------------------------------------------------------
// Thermostat configuration registers
// Decodes register writes and holds the six control settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thst_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [thst_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [thst_pkg::CsrDataWidth-1:0]  csr_wdata,
   output thst_pkg::cfg_type                       cfg
);
   import thst_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Write decode; unknown indexes leave the settings alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_SETPOINT:    cfg_in.setpoint            = signed'(csr_wdata[TempWidth-1:0]);
            REG_HYSTERESIS:  cfg_in.hysteresis          = csr_wdata[HystWidth-1:0];
            REG_HYSTERESIS2: cfg_in.second_hysteresis   = csr_wdata[HystWidth-1:0];
            REG_PROBE2_EN:   cfg_in.second_probe_enable = csr_wdata[0];
            REG_COOL_DELAY:  cfg_in.cool_delay_setting  = csr_wdata[DelayWidth-1:0];
            REG_HEAT_DELAY:  cfg_in.heat_delay_setting  = csr_wdata[DelayWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint            <= SetpointReset;
         cfg_ff.hysteresis          <= HystReset;
         cfg_ff.second_hysteresis   <= Hyst2Reset;
         cfg_ff.second_probe_enable <= ProbeEnReset;
         cfg_ff.cool_delay_setting  <= CoolDelayReset;
         cfg_ff.heat_delay_setting  <= HeatDelayReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/thst_core.sv =====
// ----------------------------------------------------------------------------
// Thermostat decision logic
// One control tick: delay countdown, relay release, relay start, lamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thst_core (
   input  wire thst_pkg::cfg_type                   cfg,
   input  wire thst_pkg::state_type                 state,
   input  wire logic signed [thst_pkg::TempWidth-1:0] main_temp,
   input  wire logic signed [thst_pkg::TempWidth-1:0] second_temp,
   output thst_pkg::state_type                      state_next,
   output thst_pkg::result_type                     result
);
   import thst_pkg::*;

   localparam int CmpWidth = TempWidth + 2;

   logic signed [CmpWidth-1:0] t;
   logic signed [CmpWidth-1:0] t2;
   logic signed [CmpWidth-1:0] sp;
   logic signed [CmpWidth-1:0] hy;
   logic signed [CmpWidth-1:0] hy2;
   logic signed [CmpWidth-1:0] half2;
   logic [WaitWidth-1:0]       cool_dec;
   logic [WaitWidth-1:0]       heat_dec;
   logic                       probe2;
   logic                       release_cool;
   logic                       release_heat;
   logic                       want_cool;
   logic                       want_heat;

   // Sign/zero extension to a common compare width
   always_comb begin
      t      = CmpWidth'(main_temp);
      t2     = CmpWidth'(second_temp);
      sp     = CmpWidth'(cfg.setpoint);
      hy     = signed'(CmpWidth'(cfg.hysteresis));
      hy2    = signed'(CmpWidth'(cfg.second_hysteresis));
      half2  = signed'(CmpWidth'(cfg.second_hysteresis[HystWidth-1:1]));
      probe2 = cfg.second_probe_enable;
   end

   // Delay counters count down to zero
   assign cool_dec = (state.cool_wait != '0) ? state.cool_wait - 1'b1 : '0;
   assign heat_dec = (state.heat_wait != '0) ? state.heat_wait - 1'b1 : '0;

   // Release and start conditions
   assign release_cool = state.cool_on && ((t <= sp) || (probe2 && (t2 < sp - hy2)));
   assign release_heat = state.heat_on && ((t >= sp) || (probe2 && (t2 > sp + hy2)));
   assign want_cool    = (t > sp + hy) && (!probe2 || (t2 >= sp - half2));
   assign want_heat    = (t < sp - hy) && (!probe2 || (t2 <= sp + half2));

   always_comb begin
      state_next.cool_wait = cool_dec;
      state_next.heat_wait = heat_dec;
      state_next.cool_on   = state.cool_on;
      state_next.heat_on   = state.heat_on;
      result.cool_lamp     = state.cool_on;
      result.heat_lamp     = state.heat_on;

      if (release_cool || release_heat) begin
         // Release drops both relays and reloads both delays
         state_next.cool_wait = WaitWidth'(cfg.cool_delay_setting) * TicksPerSetting;
         state_next.heat_wait = WaitWidth'(cfg.heat_delay_setting) * TicksPerSetting;
         state_next.cool_on   = 1'b0;
         state_next.heat_on   = 1'b0;
      end else if (!state.cool_on && !state.heat_on) begin
         // Idle: start a relay, or flash its lamp while the delay runs
         if (want_cool) begin
            if (cool_dec != '0) begin
               result.cool_lamp = state.cool_on ^ cool_dec[0];
            end else begin
               state_next.cool_on = 1'b1;
            end
         end else if (want_heat) begin
            if (heat_dec != '0) begin
               result.heat_lamp = state.heat_on ^ heat_dec[0];
            end else begin
               state_next.heat_on = 1'b1;
            end
         end
      end

      result.cool_relay = state_next.cool_on;
      result.heat_relay = state_next.heat_on;
   end

endmodule

`default_nettype wire

// ===== rtl/dual_stage_thermostat.sv =====
// Path: a tick transferred on req_ is held in the input register, then in the result
// register, and transfers on rsp_ from there; a stalled rsp_ holds it in either.
// Throughput: one tick per cycle unless rsp_ stalls. Input register feeds one pass of
// compare logic into result register; controller state updates as the result loads.
// Reset (synchronous, active high): settings return to defaults, both delay counters
// load 60, both relays off, pipeline empty.
// ----------------------------------------------------------------------------
// Two-stage thermostat
// Bang-bang cooling/heating control with hysteresis, second probe and delays.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_stage_thermostat (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Configuration writes
   input  wire logic                                  csr_wr_en,
   input  wire logic [thst_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [thst_pkg::CsrDataWidth-1:0]     csr_wdata,
   // Tick input
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [thst_pkg::TempWidth-1:0] req_main_temp,
   input  wire logic signed [thst_pkg::TempWidth-1:0] req_second_temp,
   // Result output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_cool_relay,
   output logic                                       rsp_heat_relay,
   output logic                                       rsp_cool_lamp,
   output logic                                       rsp_heat_lamp
);
   import thst_pkg::*;

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;

   logic                        in_valid_ff;
   logic signed [TempWidth-1:0] main_temp_ff;
   logic signed [TempWidth-1:0] second_temp_ff;
   logic                        out_valid_ff;
   logic                        load_out;
   logic                        load_in;

   thst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   thst_core u_core (
      .cfg         (cfg),
      .state       (state_ff),
      .main_temp   (main_temp_ff),
      .second_temp (second_temp_ff),
      .state_next  (state_in),
      .result      (result_in)
   );

   // Pipeline advance
   assign load_out  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || load_out;
   assign load_in   = req_valid && req_ready;

   // Input stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // Input stage payload
   always_ff @(posedge clock) begin
      if (load_in) begin
         main_temp_ff   <= req_main_temp;
         second_temp_ff <= req_second_temp;
      end
   end

   // Controller state advances once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cool_wait <= WaitReset;
         state_ff.heat_wait <= WaitReset;
         state_ff.cool_on   <= 1'b0;
         state_ff.heat_on   <= 1'b0;
      end else if (load_out) begin
         state_ff <= state_in;
      end
   end

   // Result stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result stage payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cool_relay = result_ff.cool_relay;
   assign rsp_heat_relay = result_ff.heat_relay;
   assign rsp_cool_lamp  = result_ff.cool_lamp;
   assign rsp_heat_lamp  = result_ff.heat_lamp;

endmodule

`default_nettype wire

// ===== rtl/thst_checker.sv =====
// ----------------------------------------------------------------------------
// Thermostat port checker
// Port-level properties of the thermostat, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thst_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_cool_relay,
   input wire logic rsp_heat_relay,
   input wire logic rsp_cool_lamp,
   input wire logic rsp_heat_lamp
);

   // Result stage empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Never drive both relays
   a_one_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_cool_relay && rsp_heat_relay))
      else $error("both relays energized");

   // Heating runs only when cooling was off and not flashing
   a_heat_lamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_heat_relay) |-> !rsp_cool_lamp)
      else $error("cool lamp lit while heating");

   a_cool_lamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cool_relay) |-> !rsp_heat_lamp)
      else $error("heat lamp lit while cooling");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cool_relay)
         && $stable(rsp_heat_relay) && $stable(rsp_cool_lamp) && $stable(rsp_heat_lamp)))
      else $error("stalled result changed");

endmodule

bind dual_stage_thermostat thst_checker u_thst_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cool_relay (rsp_cool_relay),
   .rsp_heat_relay (rsp_heat_relay),
   .rsp_cool_lamp  (rsp_cool_lamp),
   .rsp_heat_lamp  (rsp_heat_lamp)
);

`default_nettype wire

// ===== test/dual_stage_thermostat_checker.sv =====
// ----------------------------------------------------------------------------
// Thermostat result checker
// Watches the configuration port and both handshake channels of the
// two-stage thermostat. It keeps its own copy of the settings and of the
// controller state, predicts the relay and lamp outputs of every accepted
// tick and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_stage_thermostat_checker
   import thst_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0]     csr_index,
   input  wire logic [CsrDataWidth-1:0]      csr_wdata,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic signed [TempWidth-1:0]  req_main_temp,
   input  wire logic signed [TempWidth-1:0]  req_second_temp,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic                         rsp_cool_relay,
   input  wire logic                         rsp_heat_relay,
   input  wire logic                         rsp_cool_lamp,
   input  wire logic                         rsp_heat_lamp,
   output int                                fail_count,
   output int                                pending,
   output int                                tick_count,
   output int                                cool_count,
   output int                                heat_count
);

   cfg_type    csr_shadow;
   state_type  ctrl;
   result_type predicted_relays[$];

   // One control tick: count delays down, then release or start a relay
   function automatic result_type control_tick(input logic signed [TempWidth-1:0] main_t,
                                               input logic signed [TempWidth-1:0] second_t);
      int         t, t2, sp, hy, hy2, half2;
      logic       probe2, drop;
      result_type r;
      t      = int'(main_t);
      t2     = int'(second_t);
      sp     = int'(csr_shadow.setpoint);
      hy     = int'(csr_shadow.hysteresis);
      hy2    = int'(csr_shadow.second_hysteresis);
      probe2 = csr_shadow.second_probe_enable;

      if (ctrl.cool_wait != '0) ctrl.cool_wait = ctrl.cool_wait - 1'b1;
      if (ctrl.heat_wait != '0) ctrl.heat_wait = ctrl.heat_wait - 1'b1;

      // lamps show the relay state from before this tick
      r.cool_lamp = ctrl.cool_on;
      r.heat_lamp = ctrl.heat_on;

      drop = (ctrl.cool_on && (t <= sp || (probe2 && t2 < sp - hy2)))
          || (ctrl.heat_on && (t >= sp || (probe2 && t2 > sp + hy2)));

      if (drop) begin
         // release clears both relays and reloads both delays
         ctrl.cool_wait = WaitWidth'(csr_shadow.cool_delay_setting * TicksPerSetting);
         ctrl.heat_wait = WaitWidth'(csr_shadow.heat_delay_setting * TicksPerSetting);
         ctrl.cool_on   = 1'b0;
         ctrl.heat_on   = 1'b0;
      end else if (!ctrl.cool_on && !ctrl.heat_on) begin
         // second probe gates starts at half its band, rounded down
         half2 = hy2 >> 1;
         if (t > sp + hy && (!probe2 || t2 >= sp - half2)) begin
            if (ctrl.cool_wait != '0) r.cool_lamp = r.cool_lamp ^ ctrl.cool_wait[0];
            else ctrl.cool_on = 1'b1;
         end else if (t < sp - hy && (!probe2 || t2 <= sp + half2)) begin
            if (ctrl.heat_wait != '0) r.heat_lamp = r.heat_lamp ^ ctrl.heat_wait[0];
            else ctrl.heat_on = 1'b1;
         end
      end

      r.cool_relay = ctrl.cool_on;
      r.heat_relay = ctrl.heat_on;
      return r;
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, got %0b", name, want, got);
         fail_count++;
      end
   endtask

   // Sample both channels and the register port on every rising edge
   always @(posedge clock) begin : track
      result_type got, want;
      if (reset) begin
         csr_shadow = '{SetpointReset, HystReset, Hyst2Reset, ProbeEnReset,
                        CoolDelayReset, HeatDelayReset};
         ctrl       = '{WaitReset, WaitReset, 1'b0, 1'b0};
         predicted_relays.delete();
      end else begin
         // result transfer first: a result never shares an edge with its own tick
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_cool_relay, rsp_heat_relay, rsp_cool_lamp, rsp_heat_lamp};
            if (predicted_relays.size() == 0) begin
               $error("result transfer with no tick outstanding");
               fail_count++;
            end else begin
               want = predicted_relays.pop_front();
               check_field("cool_relay", want.cool_relay, got.cool_relay);
               check_field("heat_relay", want.heat_relay, got.heat_relay);
               check_field("cool_lamp", want.cool_lamp, got.cool_lamp);
               check_field("heat_lamp", want.heat_lamp, got.heat_lamp);
               cool_count += int'(want.cool_relay);
               heat_count += int'(want.heat_relay);
            end
         end

         if (req_valid && req_ready) begin
            predicted_relays.push_back(control_tick(req_main_temp, req_second_temp));
            tick_count++;
         end

         // register writes; unmapped indexes are dropped
         if (csr_wr_en) begin
            case (csr_index)
               REG_SETPOINT:    csr_shadow.setpoint            = csr_wdata[TempWidth-1:0];
               REG_HYSTERESIS:  csr_shadow.hysteresis          = csr_wdata[HystWidth-1:0];
               REG_HYSTERESIS2: csr_shadow.second_hysteresis   = csr_wdata[HystWidth-1:0];
               REG_PROBE2_EN:   csr_shadow.second_probe_enable = csr_wdata[0];
               REG_COOL_DELAY:  csr_shadow.cool_delay_setting  = csr_wdata[DelayWidth-1:0];
               REG_HEAT_DELAY:  csr_shadow.heat_delay_setting  = csr_wdata[DelayWidth-1:0];
               default: ;
            endcase
         end
      end
      pending = predicted_relays.size();
   end

endmodule

// ===== test/dual_stage_thermostat_tb.sv =====
// ----------------------------------------------------------------------------
// Two-stage thermostat testbench
// Drives control ticks into the thermostat with bursty traffic and a
// stalling receiver, reprograms the settings between phases, and leaves
// prediction and comparison to the checker instantiated beside the block.
// A directed opening covers field extremes, held-back starts, releases by
// either probe and the second probe start gate; random phases then run
// temperature sweeps across the hysteresis bands with some noise mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_stage_thermostat_tb;
   import thst_pkg::*;

   localparam int ClockHalfNs    = 4;
   localparam int RunLimitNs     = 2_400_000;
   localparam int DrainCycles    = 4;
   localparam int LongHoldCycles = 60;
   localparam int PhaseTicks     = 70;
   localparam int PhaseCount     = 10;
   localparam int HoldPhase      = 3;
   localparam int PausePhase     = 6;
   localparam int TempMax        = 2 ** (TempWidth - 1) - 1;
   localparam int TempMin        = -(2 ** (TempWidth - 1));
   localparam int DelayMax       = 2 ** DelayWidth - 1;
   localparam int DelayTop       = 60;
   localparam int HystMax        = 2 ** HystWidth - 1;

   // indexes past the register map
   localparam logic [CsrIndexWidth-1:0] RegUnmappedLow  = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegUnmappedHigh = 3'd7;

   logic                        clock;
   logic                        reset           = 1'b1;
   logic                        csr_wr_en       = 1'b0;
   logic [CsrIndexWidth-1:0]    csr_index       = '0;
   logic [CsrDataWidth-1:0]     csr_wdata       = '0;
   logic                        req_valid       = 1'b0;
   logic                        req_ready;
   logic signed [TempWidth-1:0] req_main_temp   = '0;
   logic signed [TempWidth-1:0] req_second_temp = '0;
   logic                        rsp_valid;
   logic                        rsp_ready       = 1'b0;
   logic                        rsp_cool_relay;
   logic                        rsp_heat_relay;
   logic                        rsp_cool_lamp;
   logic                        rsp_heat_lamp;

   int      fail_count;
   int      pending;
   int      tick_count;
   int      cool_count;
   int      heat_count;
   int      hold_requests  = 0;
   int      hold_served    = 0;
   int      settings_count = 0;
   cfg_type settings;
   int      walk_now;
   int      walk_target;
   int      walk_hover;

   dual_stage_thermostat DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_main_temp   (req_main_temp),
      .req_second_temp (req_second_temp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cool_relay  (rsp_cool_relay),
      .rsp_heat_relay  (rsp_heat_relay),
      .rsp_cool_lamp   (rsp_cool_lamp),
      .rsp_heat_lamp   (rsp_heat_lamp)
   );

   dual_stage_thermostat_checker relay_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_main_temp   (req_main_temp),
      .req_second_temp (req_second_temp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cool_relay  (rsp_cool_relay),
      .rsp_heat_relay  (rsp_heat_relay),
      .rsp_cool_lamp   (rsp_cool_lamp),
      .rsp_heat_lamp   (rsp_heat_lamp),
      .fail_count      (fail_count),
      .pending         (pending),
      .tick_count      (tick_count),
      .cool_count      (cool_count),
      .heat_count      (heat_count)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockHalfNs) clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #(RunLimitNs);
      $display("dual_stage_thermostat_tb failed");
      $finish;
   end

   function automatic int clamp_temp(input int v);
      return (v > TempMax) ? TempMax : (v < TempMin) ? TempMin : v;
   endfunction

   function automatic logic [DelayWidth-1:0] random_delay();
      int r;
      r = $urandom_range(0, 9);
      return (r < 4) ? 6'd0 : (r < 8) ? 6'd1 : 6'd2;
   endfunction

   // Settings for one random phase; extremes show up now and then
   function automatic cfg_type random_settings(input bit long_delays);
      cfg_type c;
      int      r;
      r = $urandom_range(0, 9);
      c.setpoint = (r == 0) ? TempWidth'(TempMin) : (r == 1) ? TempWidth'(TempMax)
                 : TempWidth'(int'($urandom_range(0, 900)) - 300);
      r = $urandom_range(0, 9);
      c.hysteresis = (r == 0) ? HystWidth'(0) : (r == 1) ? HystWidth'(HystMax)
                   : HystWidth'($urandom_range(0, 20));
      r = $urandom_range(0, 9);
      c.second_hysteresis = (r == 0) ? HystWidth'(0) : (r == 1) ? HystWidth'(HystMax)
                          : HystWidth'($urandom_range(0, 60));
      c.second_probe_enable = 1'($urandom_range(0, 1));
      // long reloads would hold back every later start, so only the last phase gets them
      c.cool_delay_setting = long_delays ? DelayWidth'(DelayMax) : random_delay();
      c.heat_delay_setting = long_delays ? DelayWidth'(DelayTop) : random_delay();
      return c;
   endfunction

   // Writes every register back to back, junk in the unused upper bits
   task automatic apply_settings(input cfg_type c);
      csr_wr_en <= 1'b1;
      csr_index <= REG_SETPOINT;
      csr_wdata <= c.setpoint;
      @(posedge clock);
      csr_index <= REG_HYSTERESIS;
      csr_wdata <= {2'($urandom), c.hysteresis};
      @(posedge clock);
      csr_index <= REG_HYSTERESIS2;
      csr_wdata <= {2'($urandom), c.second_hysteresis};
      @(posedge clock);
      csr_index <= REG_PROBE2_EN;
      csr_wdata <= {11'($urandom), c.second_probe_enable};
      @(posedge clock);
      csr_index <= REG_COOL_DELAY;
      csr_wdata <= {6'($urandom), c.cool_delay_setting};
      @(posedge clock);
      csr_index <= REG_HEAT_DELAY;
      csr_wdata <= {6'($urandom), c.heat_delay_setting};
      @(posedge clock);
      // unmapped indexes must leave the settings alone
      csr_index <= RegUnmappedLow;
      csr_wdata <= 12'($urandom);
      @(posedge clock);
      csr_index <= RegUnmappedHigh;
      csr_wdata <= 12'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings = c;
      settings_count++;
   endtask

   // Holds the tick until its transfer; ready is sampled mid-cycle
   task automatic send_tick(input int main_t, input int second_t);
      logic taken;
      req_valid       <= 1'b1;
      req_main_temp   <= TempWidth'(main_t);
      req_second_temp <= TempWidth'(second_t);
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Stops sending and waits for every outstanding result
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic start_walk();
      int sp;
      sp          = int'(settings.setpoint);
      walk_now    = sp;
      walk_target = clamp_temp(sp + int'(settings.hysteresis) + 1);
      walk_hover  = 0;
   endtask

   // Main probe sweeps back and forth across both bands, second probe near
   // the setpoint; one tick in ten is plain noise
   task automatic next_random_tick(output logic signed [TempWidth-1:0] main_t,
                                   output logic signed [TempWidth-1:0] second_t);
      int sp, hy, hy2, stride;
      sp  = int'(settings.setpoint);
      hy  = int'(settings.hysteresis);
      hy2 = int'(settings.second_hysteresis);
      if ($urandom_range(0, 9) == 0) begin
         main_t   = TempWidth'($urandom);
         second_t = TempWidth'($urandom);
      end else begin
         if (walk_hover > 0) begin
            walk_hover--;
         end else if (walk_now == walk_target) begin
            walk_target = (walk_target >= sp)
                        ? clamp_temp(sp - hy - int'($urandom_range(1, 6)))
                        : clamp_temp(sp + hy + int'($urandom_range(1, 6)));
            // long dwell lets a pending delay run out
            walk_hover = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
                       : $urandom_range(0, 6);
         end else begin
            stride = $urandom_range(1, hy / 2 + 3);
            if (walk_now < walk_target)
               walk_now = (walk_now + stride > walk_target) ? walk_target : walk_now + stride;
            else
               walk_now = (walk_now - stride < walk_target) ? walk_target : walk_now - stride;
         end
         main_t   = TempWidth'(walk_now);
         second_t = TempWidth'(clamp_temp(sp + int'($urandom_range(0, 2 * hy2 + 4)) - hy2 - 2));
      end
   endtask

   task automatic run_phase(input int count, input bit steady, input bit pause_midway);
      logic signed [TempWidth-1:0] main_t, second_t;
      int                          sent, burst, i;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (i = 0; i < burst && sent < count; i++) begin
            next_random_tick(main_t, second_t);
            send_tick(int'(main_t), int'(second_t));
            sent++;
            if (pause_midway && sent == count / 2) wait_idle();
         end
         if (!steady && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   // Receiver: stretches of ready, random toggling or stall, plus long holds on request
   initial begin : receiver
      int mode, span;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 9);
         span = $urandom_range(1, 30);
         repeat (span) begin
            if (hold_requests != hold_served) begin
               rsp_ready <= 1'b0;
               repeat (LongHoldCycles) @(posedge clock);
               hold_served++;
            end
            rsp_ready <= (mode < 4) ? 1'b1 : (mode < 8) ? 1'($urandom_range(0, 1)) : 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      cfg_type c;
      int      p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      settings = '{SetpointReset, HystReset, Hyst2Reset, ProbeEnReset,
                   CoolDelayReset, HeatDelayReset};

      // setpoint 0, narrow bands, no reload delay
      c = '{setpoint: 12'sd0, hysteresis: 10'd2, second_hysteresis: 10'd10,
            second_probe_enable: 1'b0, cool_delay_setting: 6'd0, heat_delay_setting: 6'd0};
      apply_settings(c);

      // field extremes while the power-up delay still holds starts back
      send_tick(TempMax, TempMin);
      send_tick(TempMin, TempMax);
      send_tick(0, 0);
      send_tick(TempMax, TempMax);
      // held-back cooling start, lamp flashing until the delay runs out
      repeat (57) send_tick(3, 0);
      // release at setpoint, immediate heating start, release by main probe
      send_tick(0, 0);
      send_tick(-3, 0);
      send_tick(-1, 0);
      send_tick(TempMax, 0);

      // second probe: start gate at half band and release outside the full band
      wait_idle();
      c.second_probe_enable = 1'b1;
      apply_settings(c);
      send_tick(3, -5);
      send_tick(3, -11);
      send_tick(3, -6);
      send_tick(-3, 5);
      send_tick(-3, 11);
      send_tick(-3, 6);

      // odd band: half rounds down
      wait_idle();
      c.second_hysteresis = 10'd11;
      apply_settings(c);
      send_tick(3, -6);
      send_tick(3, -5);
      send_tick(0, 0);

      // widest bands at both setpoint extremes
      wait_idle();
      c = '{setpoint: 12'sd2047, hysteresis: 10'd1023, second_hysteresis: 10'd1023,
            second_probe_enable: 1'b1, cool_delay_setting: 6'd0, heat_delay_setting: 6'd0};
      apply_settings(c);
      send_tick(TempMin, TempMin);
      send_tick(TempMax, 0);
      wait_idle();
      c.setpoint = TempWidth'(TempMin);
      apply_settings(c);
      send_tick(TempMax, TempMin);
      send_tick(TempMin, 0);

      // random phases, each under fresh settings
      for (p = 0; p < PhaseCount; p++) begin
         wait_idle();
         apply_settings(random_settings(p == PhaseCount - 1));
         start_walk();
         if (p == HoldPhase) hold_requests++;
         run_phase(PhaseTicks, p == HoldPhase || $urandom_range(0, 3) == 0, p == PausePhase);
      end

      wait_idle();
      $display("Checked %0d ticks under %0d register settings, with bursty input and stalls.",
               tick_count, settings_count);
      $display("Results with cooling on: %0d, with heating on: %0d.", cool_count, heat_count);
      if (fail_count == 0 && pending == 0)
         $display("dual_stage_thermostat_tb passed");
      else
         $display("dual_stage_thermostat_tb failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/thst_pkg.sv
rtl/thst_csr.sv
rtl/thst_core.sv
rtl/dual_stage_thermostat.sv
rtl/thst_checker.sv
test/dual_stage_thermostat_checker.sv
test/dual_stage_thermostat_tb.sv
